// File: rtl/core/axcc_pkg.sv
// ----------------------------------------------------------------------------
// axcc_pkg
// Shared types and codes for the axis command check and convert block:
// sequencer states, error codes, configuration register indexes and command codes.
// ----------------------------------------------------------------------------
package axcc_pkg;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_VEL     = 6'b000010,
      S_CHECK   = 6'b000100,
      S_MUL_LO  = 6'b001000,
      S_MUL_HI  = 6'b010000,
      S_FINISH  = 6'b100000
   } state_type;

   // rejection codes, first failing check wins
   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_POS_DISABLED = 3'd1,
      ERR_NEG_DISABLED = 3'd2,
      ERR_UPPER_LIMIT  = 3'd3,
      ERR_LOWER_LIMIT  = 3'd4
   } error_type;

   // configuration register indexes
   localparam logic [2:0] CSR_CYCLE_FREQUENCY = 3'd0;
   localparam logic [2:0] CSR_POSITIVE_ENABLE = 3'd1;
   localparam logic [2:0] CSR_NEGATIVE_ENABLE = 3'd2;
   localparam logic [2:0] CSR_UPPER_LIMIT     = 3'd3;
   localparam logic [2:0] CSR_LOWER_LIMIT     = 3'd4;
   localparam logic [2:0] CSR_ZERO_OFFSET     = 3'd5;
   localparam logic [2:0] CSR_COUNTS_SCALE    = 3'd6;
   localparam logic [2:0] CSR_OUTPUT_MODE     = 3'd7;

   // command codes
   localparam logic CMD_CHECK = 1'b0;
   localparam logic CMD_SYNC  = 1'b1;

endpackage

// File: rtl/core/axis_command_check_and_convert.sv
// ----------------------------------------------------------------------------
// axis_command_check_and_convert
// Checks one axis position command per control cycle against direction
// enables and soft limits, and converts accepted commands to drive counts.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one command word (command, position_command);
//    a word is taken when req_valid is high and req_stall is low.
//  - rsp_ channel returns one result word per command (accepted, error_code,
//    velocity_command, drive_counts); taken when rsp_valid and !rsp_stall.
//  - csr_ channel writes the configuration registers by index; csr_ready is
//    always high, writes are expected only while the block is idle.
//  - one shared 33x32 multiplier runs under a small sequencer: velocity
//    product, then the low and high partial products of the count scaling.
//    A check command that passes steps through S_VEL, S_CHECK, S_MUL_LO,
//    S_MUL_HI and S_FINISH, a rejected one through S_VEL, S_CHECK and
//    S_FINISH (no count scaling), a sync command through S_FINISH alone;
//    req_stall is high until S_IDLE, so no new word is taken while busy.
//  - the output register parts the two sides: a new word is accepted while
//    a result still waits; if the receiver stalls, the next result holds in
//    the last sequencer step and req_stall stays high until it is taken.
//  - reset loads the register defaults, clears the position history and
//    empties the output register.
// ----------------------------------------------------------------------------
module axis_command_check_and_convert (
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic signed [31:0]  req_position_command,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_accepted,
   output logic [2:0]          rsp_error_code,
   output logic signed [48:0]  rsp_velocity_command,
   output logic signed [31:0]  rsp_drive_counts,
   // configuration channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [32:0]         csr_data
);

   // configuration registers
   logic [15:0]        cycle_frequency_ff;
   logic               positive_enable_ff;
   logic               negative_enable_ff;
   logic signed [32:0] upper_limit_ff;
   logic signed [32:0] lower_limit_ff;
   logic signed [31:0] zero_offset_ff;
   logic signed [31:0] counts_scale_ff;
   logic               output_mode_ff;

   // sequencer and datapath registers
   axcc_pkg::state_type state_ff, state_in;
   logic signed [31:0] prev_ff;
   logic signed [31:0] pos_ff;
   logic               neg_ff;
   logic signed [48:0] vel_ff;
   logic [2:0]         err_ff;
   logic               use_scale_ff;
   logic               cnt_neg_ff;
   logic [16:0]        mx_hi_ff;
   logic [32:0]        mul_a_ff;
   logic [31:0]        mul_b_ff;
   logic [64:0]        prod_ff;
   logic [32:0]        rnd_ff;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_accepted_ff;
   logic [2:0]         rsp_error_code_ff;
   logic signed [48:0] rsp_velocity_ff;
   logic signed [31:0] rsp_counts_ff;

   logic               req_take;
   logic               out_free;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic signed [48:0] vel;
   logic               vel_pos;
   logic               vel_neg;
   logic signed [32:0] raw;
   logic [2:0]         err;
   logic signed [48:0] src;
   logic [48:0]        src_mag;
   logic [31:0]        scale_mag;
   logic [64:0]        rnd_sum;
   logic [49:0]        q;
   logic signed [31:0] counts;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != axcc_pkg::S_IDLE);
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_frequency_ff <= 16'd1000;
         positive_enable_ff <= 1'b1;
         negative_enable_ff <= 1'b1;
         upper_limit_ff     <= 33'sh0_FFFF_FFFF;
         lower_limit_ff     <= 33'sh1_0000_0000;
         zero_offset_ff     <= '0;
         counts_scale_ff    <= 32'sd65536;
         output_mode_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            axcc_pkg::CSR_CYCLE_FREQUENCY: cycle_frequency_ff <= csr_data[15:0];
            axcc_pkg::CSR_POSITIVE_ENABLE: positive_enable_ff <= csr_data[0];
            axcc_pkg::CSR_NEGATIVE_ENABLE: negative_enable_ff <= csr_data[0];
            axcc_pkg::CSR_UPPER_LIMIT:     upper_limit_ff     <= csr_data;
            axcc_pkg::CSR_LOWER_LIMIT:     lower_limit_ff     <= csr_data;
            axcc_pkg::CSR_ZERO_OFFSET:     zero_offset_ff     <= csr_data[31:0];
            axcc_pkg::CSR_COUNTS_SCALE:    counts_scale_ff    <= csr_data[31:0];
            axcc_pkg::CSR_OUTPUT_MODE:     output_mode_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // position difference magnitude for the velocity product
   always_comb begin
      diff     = 33'(req_position_command) - 33'(prev_ff);
      diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
   end

   // velocity, offset position and checks
   always_comb begin
      vel     = neg_ff ? -$signed(prod_ff[48:0]) : $signed(prod_ff[48:0]);
      vel_pos = (prod_ff[48:0] != '0) && !neg_ff;
      vel_neg = (prod_ff[48:0] != '0) && neg_ff;
      raw     = 33'(pos_ff) + 33'(zero_offset_ff);
      priority if (vel_pos && !positive_enable_ff)
         err = axcc_pkg::ERR_POS_DISABLED;
      else if (vel_neg && !negative_enable_ff)
         err = axcc_pkg::ERR_NEG_DISABLED;
      else if (vel_pos && (raw > upper_limit_ff))
         err = axcc_pkg::ERR_UPPER_LIMIT;
      else if (vel_neg && (raw < lower_limit_ff))
         err = axcc_pkg::ERR_LOWER_LIMIT;
      else
         err = axcc_pkg::ERR_NONE;
      src       = output_mode_ff ? vel : 49'(raw);
      src_mag   = src[48] ? 49'(-src) : 49'(src);
      scale_mag = counts_scale_ff[31] ? 32'(-counts_scale_ff) : 32'(counts_scale_ff);
   end

   // rounding of the low partial product, final sum and saturation
   always_comb begin
      rnd_sum = {1'b0, prod_ff[63:0]} + 65'h0_8000_0000;
      q       = 50'(prod_ff[47:0]) + 50'(rnd_ff);
      if (!use_scale_ff)
         counts = '0;
      else if (cnt_neg_ff)
         counts = (q >= 50'h0_8000_0000) ? 32'sh8000_0000 : 32'(-$signed(q));
      else
         counts = (q > 50'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
   end

   // next sequencer state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         axcc_pkg::S_IDLE: begin
            if (req_take)
               state_in = (req_command == axcc_pkg::CMD_SYNC) ? axcc_pkg::S_FINISH
                                                                : axcc_pkg::S_VEL;
         end
         axcc_pkg::S_VEL:    state_in = axcc_pkg::S_CHECK;
         axcc_pkg::S_CHECK:  state_in = (err == axcc_pkg::ERR_NONE) ? axcc_pkg::S_MUL_LO
                                                                      : axcc_pkg::S_FINISH;
         axcc_pkg::S_MUL_LO: state_in = axcc_pkg::S_MUL_HI;
         axcc_pkg::S_MUL_HI: state_in = axcc_pkg::S_FINISH;
         axcc_pkg::S_FINISH: begin
            if (out_free)
               state_in = axcc_pkg::S_IDLE;
         end
         default: state_in = axcc_pkg::S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= axcc_pkg::S_IDLE;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         // history reload on sync, or on a command that passed the checks
         if (req_take && (req_command == axcc_pkg::CMD_SYNC))
            prev_ff <= req_position_command;
         else if ((state_ff == axcc_pkg::S_CHECK) && (err == axcc_pkg::ERR_NONE))
            prev_ff <= pos_ff;
      end
   end

   // shared multiplier, product registered every cycle
   always_ff @(posedge clock) begin
      prod_ff <= 65'(mul_a_ff) * 65'(mul_b_ff);
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         axcc_pkg::S_IDLE: begin
            if (req_take) begin
               pos_ff   <= req_position_command;
               neg_ff   <= diff[32];
               mul_a_ff <= diff_mag;
               mul_b_ff <= 32'(cycle_frequency_ff);
               vel_ff   <= '0;
               err_ff   <= axcc_pkg::ERR_NONE;
               use_scale_ff <= 1'b0;
            end
         end
         axcc_pkg::S_CHECK: begin
            vel_ff       <= vel;
            err_ff       <= err;
            use_scale_ff <= (err == axcc_pkg::ERR_NONE);
            cnt_neg_ff   <= src[48] ^ counts_scale_ff[31];
            mx_hi_ff     <= src_mag[48:32];
            mul_a_ff     <= 33'(src_mag[31:0]);
            mul_b_ff     <= scale_mag;
         end
         axcc_pkg::S_MUL_LO: begin
            mul_a_ff <= 33'(mx_hi_ff);
         end
         axcc_pkg::S_MUL_HI: begin
            rnd_ff <= rnd_sum[64:32];
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == axcc_pkg::S_FINISH) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == axcc_pkg::S_FINISH) && out_free) begin
         rsp_accepted_ff   <= (err_ff == axcc_pkg::ERR_NONE);
         rsp_error_code_ff <= err_ff;
         rsp_velocity_ff   <= vel_ff;
         rsp_counts_ff     <= counts;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = rsp_accepted_ff;
   assign rsp_error_code       = rsp_error_code_ff;
   assign rsp_velocity_command = rsp_velocity_ff;
   assign rsp_drive_counts     = rsp_counts_ff;

   // a rejected word carries an error code and no counts
   a_reject_no_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |->
         (rsp_drive_counts == '0) && (rsp_error_code != axcc_pkg::ERR_NONE))
      else $error("rejected result carries counts or no error code");

   // an accepted word never carries an error code
   a_accept_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_error_code == axcc_pkg::ERR_NONE))
      else $error("accepted result carries an error code");

   // history only moves after reset, on a taken command word or in the check state
   a_history_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(prev_ff) |->
         $past(reset) || $past(req_valid && !req_stall) ||
         $past(state_ff == axcc_pkg::S_CHECK))
      else $error("position history changed outside an update");

   // a finished result lands in the output register once it is free
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == axcc_pkg::S_FINISH) && out_free) |=>
         rsp_valid && (state_ff == axcc_pkg::S_IDLE))
      else $error("finished result not presented");

endmodule
